>>> rtl/ptqm_pkg.sv
// Package for the priority task queue manager: opcodes, status codes, limits.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptqm_pkg;
  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_DELETE  = 3'd1;
  localparam logic [2:0] OP_BLOCK   = 3'd2;
  localparam logic [2:0] OP_UNBLOCK = 3'd3;
  localparam logic [2:0] OP_SUSPEND = 3'd4;
  localparam logic [2:0] OP_RESUME  = 3'd5;
  localparam logic [2:0] OP_SETPRI  = 3'd6;
  // reserved code: no effect, answers ok
  localparam logic [2:0] OP_NOP     = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_BADPRI   = 3'd2;
  localparam logic [2:0] ST_BADCLASS = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [3:0] MAX_PRIORITY = 4'd9;
endpackage
`default_nettype wire

>>> rtl/priority_task_queue_manager.sv
// Priority task queue manager top level: slot table, four linked queues, sequencer.
// Depends on ptqm_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One command beat in, one status beat out. The block handles one command at a
// time. An insert into a ready or suspended-ready queue walks that queue one link
// per cycle through a single priority comparator. The result waits in an output
// register; the next command is taken once that register has been emptied or is
// being taken.
module priority_task_queue_manager
  import ptqm_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], task_id[6:3], priority_req[10:7], task_class[12:11]
  input  wire  [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[2:0], ready_head_valid[3], ready_head_id[7:4], ready_count[12:8],
  // suspended_ready_count[17:13], blocked_count[22:18], suspended_blocked_count[27:23]
  output logic [31:0] m_axis_tdata
);
  localparam int SW = (MAX_TASKS >= 16) ? $clog2(MAX_TASKS + 1) : 4;
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UNLINK = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]  state_q;
  logic [MAX_TASKS-1:0] valid_q;
  logic [MAX_TASKS-1:0] blk_q, sus_q;
  logic [3:0]  pri_q [MAX_TASKS];
  logic [IW-1:0] nxt_q [MAX_TASKS];
  logic [IW-1:0] prv_q [MAX_TASKS];
  logic [IW-1:0] head_q [4];
  logic [IW-1:0] tail_q [4];
  logic [CW-1:0] cnt_q [4];

  logic [2:0]  op_q;
  logic [3:0]  pr_q;
  logic [IW-1:0] s_q, cur_q;
  logic [CW-1:0] i_q;
  logic        ovalid_q;
  logic [2:0]  stat_q;

  wire [2:0] in_op  = s_axis_tdata[2:0];
  wire [3:0] in_id  = s_axis_tdata[6:3];
  wire [3:0] in_pri = s_axis_tdata[10:7];
  wire [1:0] in_cls = s_axis_tdata[12:11];
  wire       fire_in = s_axis_tvalid && s_axis_tready;

  wire [SW-1:0]  id_w    = SW'(in_id);
  wire           id_in   = id_w < SW'(MAX_TASKS);
  wire [IW-1:0]  id_s    = IW'(in_id);
  wire           exists  = id_in && valid_q[id_s];

  wire [1:0] qs = {blk_q[s_q], sus_q[s_q]};

  assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready);

  // Sequencer: decode/check in IDLE; unlink; insert (S_INS handles empty and
  // blocked cases, then the walk compares one link per cycle).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      ovalid_q <= 1'b0;
      stat_q   <= ST_OK;
      for (int k = 0; k < 4; k++) begin
        head_q[k] <= '0;
        tail_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (fire_in) begin
          op_q <= in_op;
          pr_q <= in_pri;
          s_q  <= id_s;
          state_q <= S_UNLINK;
          stat_q <= ST_OK;
          if (in_op == OP_CREATE) begin
            if (exists) stat_q <= ST_DUP;
            else if (in_pri > MAX_PRIORITY) stat_q <= ST_BADPRI;
            else if (in_cls > 2'd1) stat_q <= ST_BADCLASS;
            else if (!id_in) stat_q <= ST_FULL;
            else begin
              valid_q[id_s] <= 1'b1;
              pri_q[id_s]   <= in_pri;
              blk_q[id_s]   <= 1'b0;
              sus_q[id_s]   <= 1'b0;
              state_q <= S_INS;
            end
            if (exists || in_pri > MAX_PRIORITY || in_cls > 2'd1 || !id_in)
              state_q <= S_DONE;
          end else if (in_op == OP_NOP) begin
            state_q <= S_DONE;
          end else if (!exists) begin
            stat_q <= ST_NOTFOUND;
            state_q <= S_DONE;
          end else if (in_op == OP_SETPRI && in_pri > MAX_PRIORITY) begin
            stat_q <= ST_BADPRI;
            state_q <= S_DONE;
          end
        end
        S_UNLINK: begin
          if (cnt_q[qs] != '0) begin
            if (head_q[qs] == s_q && tail_q[qs] == s_q) begin
              head_q[qs] <= '0;
              tail_q[qs] <= '0;
            end else if (head_q[qs] == s_q) begin
              head_q[qs] <= nxt_q[s_q];
            end else if (tail_q[qs] == s_q) begin
              tail_q[qs] <= prv_q[s_q];
            end else begin
              nxt_q[prv_q[s_q]] <= nxt_q[s_q];
              prv_q[nxt_q[s_q]] <= prv_q[s_q];
            end
            cnt_q[qs] <= cnt_q[qs] - 1'b1;
          end
          state_q <= S_INS;
          case (op_q)
            OP_DELETE: begin valid_q[s_q] <= 1'b0; state_q <= S_DONE; end
            OP_BLOCK:   blk_q[s_q] <= 1'b1;
            OP_UNBLOCK: blk_q[s_q] <= 1'b0;
            OP_SUSPEND: sus_q[s_q] <= 1'b1;
            OP_RESUME:  sus_q[s_q] <= 1'b0;
            default:    pri_q[s_q] <= pr_q;
          endcase
        end
        S_INS: begin
          if (cnt_q[qs] == '0) begin
            head_q[qs] <= s_q;
            tail_q[qs] <= s_q;
            cnt_q[qs]  <= CW'(1);
            state_q <= S_DONE;
          end else if (qs[1]) begin
            nxt_q[s_q] <= head_q[qs];
            prv_q[head_q[qs]] <= s_q;
            head_q[qs] <= s_q;
            cnt_q[qs]  <= cnt_q[qs] + 1'b1;
            state_q <= S_DONE;
          end else begin
            cur_q <= head_q[qs];
            i_q   <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (pri_q[cur_q] > pri_q[s_q]) begin
            nxt_q[s_q] <= cur_q;
            if (cur_q == head_q[qs]) head_q[qs] <= s_q;
            else begin
              nxt_q[prv_q[cur_q]] <= s_q;
              prv_q[s_q] <= prv_q[cur_q];
            end
            prv_q[cur_q] <= s_q;
            cnt_q[qs] <= cnt_q[qs] + 1'b1;
            state_q <= S_DONE;
          end else if (i_q + 1'b1 < cnt_q[qs]) begin
            cur_q <= nxt_q[cur_q];
            i_q   <= i_q + 1'b1;
          end else begin
            nxt_q[tail_q[qs]] <= s_q;
            prv_q[s_q] <= tail_q[qs];
            tail_q[qs] <= s_q;
            cnt_q[qs] <= cnt_q[qs] + 1'b1;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          ovalid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  wire rv = cnt_q[0] != '0;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {4'd0, 5'(cnt_q[3]), 5'(cnt_q[2]), 5'(cnt_q[1]), 5'(cnt_q[0]),
                         rv ? 4'(head_q[0]) : 4'd0, rv, stat_q};

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != S_IDLE) |-> !s_axis_tready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  property p_done_result;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_DONE) |=> m_axis_tvalid;
  endproperty
  a_done_result: assert property (p_done_result) else $error("result lost");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      (CW'(cnt_q[0]) + cnt_q[1] + cnt_q[2] + cnt_q[3]) <= CW'(MAX_TASKS);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue counts exceed slots");
endmodule
`default_nettype wire

>>> verif/ptqm_checker.sv
// Checker for the priority task queue manager: watches both stream channels,
// keeps its own copy of the four linked queues and compares every result beat.
// Depends on ptqm_pkg.
`timescale 1ns / 1ps
module ptqm_checker
  import ptqm_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [15:0] s_axis_tdata,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [31:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int NT = 16;

  logic       valid_q [NT];
  logic [3:0] pri_q   [NT];
  logic       blk_q   [NT];
  logic       sus_q   [NT];
  logic [3:0] nxt_q   [NT];
  logic [3:0] prv_q   [NT];
  logic [3:0] head_q  [4];
  logic [3:0] tail_q  [4];
  logic [4:0] cnt_q   [4];

  logic [27:0] status_fifo [$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = status_fifo.size();

  function automatic int qsel(int s);
    return int'({blk_q[s], sus_q[s]});
  endfunction

  function automatic void unlink_task(int s);
    int q;
    q = qsel(s);
    if (cnt_q[q] == 0) return;
    if (head_q[q] == s && tail_q[q] == s) begin
      head_q[q] = '0;
      tail_q[q] = '0;
    end else if (head_q[q] == s) begin
      head_q[q] = nxt_q[s];
    end else if (tail_q[q] == s) begin
      tail_q[q] = prv_q[s];
    end else begin
      nxt_q[prv_q[s]] = nxt_q[s];
      prv_q[nxt_q[s]] = prv_q[s];
    end
    cnt_q[q] = cnt_q[q] - 5'd1;
  endfunction

  function automatic void link_task(int s);
    int q, cur, n, p;
    q = qsel(s);
    if (cnt_q[q] == 0) begin
      head_q[q] = 4'(s);
      tail_q[q] = 4'(s);
      cnt_q[q] = 5'd1;
      return;
    end
    if (q >= 2) begin
      nxt_q[s] = head_q[q];
      prv_q[head_q[q]] = 4'(s);
      head_q[q] = 4'(s);
      cnt_q[q] = cnt_q[q] + 5'd1;
      return;
    end
    cur = int'(head_q[q]);
    n = int'(cnt_q[q]);
    for (int i = 0; i < n; i++) begin
      if (pri_q[cur] > pri_q[s]) begin
        nxt_q[s] = 4'(cur);
        if (cur == head_q[q]) head_q[q] = 4'(s);
        else begin
          p = int'(prv_q[cur]);
          nxt_q[p] = 4'(s);
          prv_q[s] = 4'(p);
        end
        prv_q[cur] = 4'(s);
        cnt_q[q] = cnt_q[q] + 5'd1;
        return;
      end
      if (i + 1 < n) cur = int'(nxt_q[cur]);
    end
    cur = int'(tail_q[q]);
    nxt_q[cur] = 4'(s);
    prv_q[s] = 4'(cur);
    tail_q[q] = 4'(s);
    cnt_q[q] = cnt_q[q] + 5'd1;
  endfunction

  function automatic logic [27:0] apply_command(logic [15:0] beat);
    logic [2:0] op, st;
    logic [3:0] id, pr;
    logic [1:0] cls;
    op = beat[2:0];
    id = beat[6:3];
    pr = beat[10:7];
    cls = beat[12:11];
    st = ST_OK;
    if (op == OP_CREATE) begin
      if (valid_q[id]) st = ST_DUP;
      else if (pr > MAX_PRIORITY) st = ST_BADPRI;
      else if (cls > 2'd1) st = ST_BADCLASS;
      else begin
        valid_q[id] = 1'b1;
        pri_q[id] = pr;
        blk_q[id] = 1'b0;
        sus_q[id] = 1'b0;
        link_task(int'(id));
      end
    end else if (op <= OP_SETPRI) begin
      if (!valid_q[id]) st = ST_NOTFOUND;
      else if (op == OP_SETPRI && pr > MAX_PRIORITY) st = ST_BADPRI;
      else begin
        unlink_task(int'(id));
        case (op)
          OP_DELETE:  valid_q[id] = 1'b0;
          OP_BLOCK:   blk_q[id] = 1'b1;
          OP_UNBLOCK: blk_q[id] = 1'b0;
          OP_SUSPEND: sus_q[id] = 1'b1;
          OP_RESUME:  sus_q[id] = 1'b0;
          default:    pri_q[id] = pr;
        endcase
        if (op != OP_DELETE) link_task(int'(id));
      end
    end
    return {cnt_q[3], cnt_q[2], cnt_q[1], cnt_q[0],
            (cnt_q[0] != 0) ? head_q[0] : 4'd0, cnt_q[0] != 0, st};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [27:0] want;
    if (!rst_ni) begin
      fails = 0;
      status_fifo.delete();
      for (int i = 0; i < NT; i++) valid_q[i] = 1'b0;
      for (int i = 0; i < 4; i++) begin
        head_q[i] = '0;
        tail_q[i] = '0;
        cnt_q[i] = '0;
      end
    end else begin
      if (s_axis_tvalid && s_axis_tready) status_fifo.push_back(apply_command(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_fifo.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          want = status_fifo.pop_front();
          if (m_axis_tdata[2:0] != want[2:0])
            report_mismatch("status", m_axis_tdata[2:0], want[2:0]);
          if (m_axis_tdata[3] != want[3])
            report_mismatch("ready_head_valid", m_axis_tdata[3], want[3]);
          if (m_axis_tdata[7:4] != want[7:4])
            report_mismatch("ready_head_id", m_axis_tdata[7:4], want[7:4]);
          if (m_axis_tdata[12:8] != want[12:8])
            report_mismatch("ready_count", m_axis_tdata[12:8], want[12:8]);
          if (m_axis_tdata[17:13] != want[17:13])
            report_mismatch("suspended_ready_count", m_axis_tdata[17:13], want[17:13]);
          if (m_axis_tdata[22:18] != want[22:18])
            report_mismatch("blocked_count", m_axis_tdata[22:18], want[22:18]);
          if (m_axis_tdata[27:23] != want[27:23])
            report_mismatch("suspended_blocked_count", m_axis_tdata[27:23], want[27:23]);
        end
      end
    end
  end
endmodule

>>> verif/tb_top.sv
// Testbench top for the priority task queue manager: clock, reset, command
// stimulus and verdict. Depends on ptqm_pkg and ptqm_checker.
`timescale 1ns / 1ps
module tb_top;
  import ptqm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          cycles;
  logic        stall_mode;

  priority_task_queue_manager dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  ptqm_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: alternates between a free-flowing stretch and a stalling one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_cmd(logic [2:0] op, logic [3:0] id, logic [3:0] pr, logic [1:0] cls);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {3'b0, cls, pr, id, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_random;
    logic [2:0] op;
    logic [3:0] pr;
    logic [1:0] cls;
    // mostly valid creates and moves on a small id set; some out-of-range noise
    op  = (($urandom_range(0, 9) == 0) ? OP_NOP : 3'($urandom_range(0, 6)));
    pr  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    cls = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
    send_cmd(op, 4'($urandom), pr, cls);
  endtask

  initial begin
    int burst;
    cycles = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: creates, duplicates, range errors, each move, missing ids
    send_cmd(OP_DELETE, 4'd3, 4'd0, 2'd0);
    send_cmd(OP_CREATE, 4'd0, 4'd9, 2'd0);
    send_cmd(OP_CREATE, 4'd15, 4'd0, 2'd1);
    send_cmd(OP_CREATE, 4'd5, 4'd9, 2'd1);
    send_cmd(OP_CREATE, 4'd7, 4'd4, 2'd0);
    send_cmd(OP_CREATE, 4'd5, 4'd1, 2'd0);
    send_cmd(OP_CREATE, 4'd2, 4'd15, 2'd0);
    send_cmd(OP_CREATE, 4'd2, 4'd10, 2'd0);
    send_cmd(OP_CREATE, 4'd2, 4'd3, 2'd3);
    send_cmd(OP_CREATE, 4'd2, 4'd3, 2'd2);
    send_cmd(OP_BLOCK, 4'd15, 4'd0, 2'd0);
    send_cmd(OP_BLOCK, 4'd7, 4'd0, 2'd0);
    send_cmd(OP_BLOCK, 4'd15, 4'd0, 2'd0);
    send_cmd(OP_SUSPEND, 4'd15, 4'd0, 2'd0);
    send_cmd(OP_SUSPEND, 4'd0, 4'd0, 2'd0);
    send_cmd(OP_SETPRI, 4'd7, 4'd2, 2'd0);
    send_cmd(OP_SETPRI, 4'd5, 4'd12, 2'd0);
    send_cmd(OP_SETPRI, 4'd5, 4'd0, 2'd0);
    send_cmd(OP_UNBLOCK, 4'd7, 4'd0, 2'd0);
    send_cmd(OP_RESUME, 4'd0, 4'd0, 2'd0);
    send_cmd(OP_UNBLOCK, 4'd9, 4'd0, 2'd0);
    send_cmd(OP_SETPRI, 4'd9, 4'd3, 2'd0);
    send_cmd(OP_NOP, 4'd5, 4'd15, 2'd3);
    send_cmd(OP_DELETE, 4'd15, 4'd0, 2'd0);

    // hold off until the block has drained
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < 450; ) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) send_random();
      n += burst;
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 25));
    end
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
